FILE: rtl/sha256_message_hasher_core_assert.svh
// Assertion macros for the SHA-256 message hasher
`ifndef SHA256_MESSAGE_HASHER_CORE_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_CORE_ASSERT_SVH
// Implication checked every clock, off while reset is low.
`define SHA_ASSERT_IMPL(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication.
`define SHA_ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

FILE: rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Types, constants and the rotate function shared by the SHA-256 hasher.
// ----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;
    typedef logic [31:0] word_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic       KIND_DATA   = 1'b0;
    localparam logic       KIND_FINISH = 1'b1;

    typedef struct packed {
        logic load_iv;   // reload initial hash
        logic start;     // start one compression
        logic capture;   // copy chaining value into the output register
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
    } dp_stat_t;

    localparam word_t IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam word_t K [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

    function automatic word_t rotr(input word_t v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction
endpackage
`default_nettype wire

FILE: rtl/sha_datapath.sv
// ----------------------------------------------------------------------------
// sha_datapath
// Block buffer, message schedule, round unit (one round per cycle), chaining value.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_datapath (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire sha_pkg::dp_cmd_t  cmd,
    input  wire logic              byte_we,
    input  wire logic [5:0]        byte_addr,
    input  wire logic [7:0]        byte_data,
    output sha_pkg::dp_stat_t      stat,
    output logic [255:0]           digest
);
    sha_pkg::word_t h_reg [8];
    sha_pkg::word_t v_reg [8];
    sha_pkg::word_t w_reg [16];
    sha_pkg::word_t blk_reg [16];
    logic [255:0]   digest_reg;
    logic [5:0]     rnd_reg;
    logic           busy_reg;
    logic           fold_reg;

    sha_pkg::word_t w_cur, g0, g1, s0, s1, ch, maj, t1, t2;

    always_comb begin
        g0 = sha_pkg::rotr(w_reg[1], 7) ^ sha_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        g1 = sha_pkg::rotr(w_reg[14], 17) ^ sha_pkg::rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        if (rnd_reg < 6'd16) begin
            w_cur = blk_reg[rnd_reg[3:0]];
        end else begin
            w_cur = w_reg[0] + g0 + w_reg[9] + g1;
        end
        s1  = sha_pkg::rotr(v_reg[4], 6) ^ sha_pkg::rotr(v_reg[4], 11)
            ^ sha_pkg::rotr(v_reg[4], 25);
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1  = v_reg[7] + s1 + ch + sha_pkg::K[rnd_reg] + w_cur;
        s0  = sha_pkg::rotr(v_reg[0], 2) ^ sha_pkg::rotr(v_reg[0], 13)
            ^ sha_pkg::rotr(v_reg[0], 22);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2  = s0 + maj;
    end

    // byte 0 of a word is its most significant byte
    always_ff @(posedge aclk) begin
        if (byte_we) begin
            blk_reg[byte_addr[5:2]][{~byte_addr[1:0], 3'b000} +: 8] <= byte_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fold_reg <= 1'b0;
            rnd_reg  <= '0;
            for (int i = 0; i < 8; i++) h_reg[i] <= sha_pkg::IV[i];
        end else begin
            fold_reg <= 1'b0;
            if (cmd.capture) begin
                digest_reg <= {h_reg[0], h_reg[1], h_reg[2], h_reg[3],
                               h_reg[4], h_reg[5], h_reg[6], h_reg[7]};
            end
            if (cmd.load_iv) begin
                for (int i = 0; i < 8; i++) h_reg[i] <= sha_pkg::IV[i];
            end else if (cmd.start) begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
                for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
            end else if (busy_reg) begin
                for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i + 1];
                w_reg[15] <= w_cur;
                v_reg[7] <= v_reg[6]; v_reg[6] <= v_reg[5]; v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2]; v_reg[2] <= v_reg[1]; v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
                rnd_reg  <= rnd_reg + 6'd1;
                if (rnd_reg == 6'd63) begin
                    fold_reg <= 1'b1;
                end
            end else if (fold_reg) begin
                for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
            end
            if (busy_reg && rnd_reg == 6'd63) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign stat.busy = busy_reg | fold_reg;
    assign digest = digest_reg;

    `include "sha256_message_hasher_core_assert.svh"
    `SHA_ASSERT_NEXT(a_fold_after_last, aclk, aresetn,
        busy_reg && rnd_reg == 6'd63, fold_reg && !busy_reg)
    `SHA_ASSERT_IMPL(a_no_start_busy, aclk, aresetn, cmd.start, !busy_reg && !fold_reg)
    `SHA_ASSERT_IMPL(a_no_write_busy, aclk, aresetn, byte_we, !busy_reg)
endmodule
`default_nettype wire

FILE: rtl/sha_ctrl.sv
// ----------------------------------------------------------------------------
// sha_ctrl
// Controller: byte intake, padding sequence, compression launch, digest output.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              in_kind,
    input  wire logic [7:0]        in_byte,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output sha_pkg::dp_cmd_t       cmd,
    input  wire sha_pkg::dp_stat_t stat,
    output logic                   byte_we,
    output logic [5:0]             byte_addr,
    output logic [7:0]             byte_data
);
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_WAIT = 6'b000010,
        ST_ZERO = 6'b000100,
        ST_LEN  = 6'b001000,
        ST_LAST = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] cnt_reg, cnt_next;
    logic [2:0]  lix_reg, lix_next;
    logic        pad_reg, pad_next;   // finishing
    logic        go_reg, go_next;     // start issued, wait for busy
    logic        out_valid_reg, out_valid_next;

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        cnt_next   = cnt_reg;
        lix_next   = lix_reg;
        pad_next   = pad_reg;
        go_next    = 1'b0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        in_ready   = 1'b0;
        cmd        = '0;
        byte_we    = 1'b0;
        byte_addr  = fill_reg;
        byte_data  = in_byte;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_kind == sha_pkg::KIND_DATA) begin
                        byte_we   = 1'b1;
                        cnt_next  = cnt_reg + 64'd8;
                        fill_next = fill_reg + 6'd1;
                        if (fill_reg == 6'd63) begin
                            cmd.start  = 1'b1;
                            go_next    = 1'b1;
                            state_next = ST_WAIT;
                        end
                    end else begin
                        byte_we    = 1'b1;
                        byte_data  = sha_pkg::PAD_BYTE;
                        fill_next  = fill_reg + 6'd1;
                        pad_next   = 1'b1;
                        // pad byte closes the block: compress it first
                        if (fill_reg == 6'd63) begin
                            cmd.start  = 1'b1;
                            go_next    = 1'b1;
                            state_next = ST_WAIT;
                        end else begin
                            state_next = ST_ZERO;
                        end
                    end
                end
            end
            ST_ZERO: begin
                byte_data = 8'h00;
                if (fill_reg == sha_pkg::LEN_POS) begin
                    lix_next   = 3'd0;
                    state_next = ST_LEN;
                end else begin
                    byte_we   = 1'b1;
                    fill_next = fill_reg + 6'd1;
                    if (fill_reg == 6'd63) begin
                        cmd.start  = 1'b1;
                        go_next    = 1'b1;
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_LEN: begin
                byte_we   = 1'b1;
                byte_addr = {3'b111, lix_reg};
                byte_data = cnt_reg[8 * (7 - lix_reg) +: 8];
                lix_next  = lix_reg + 3'd1;
                if (lix_reg == 3'd7) begin
                    cmd.start  = 1'b1;
                    go_next    = 1'b1;
                    fill_next  = '0;
                    state_next = ST_LAST;
                end
            end
            ST_WAIT: begin
                if (!go_reg && !stat.busy) begin
                    state_next = pad_reg ? ST_ZERO : ST_IDLE;
                end
            end
            ST_LAST: begin
                if (!go_reg && !stat.busy) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!out_valid_reg || out_ready) begin
                    cmd.capture    = 1'b1;
                    cmd.load_iv    = 1'b1;
                    out_valid_next = 1'b1;
                    cnt_next       = '0;
                    fill_next      = '0;
                    pad_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            cnt_reg   <= '0;
            lix_reg   <= '0;
            pad_reg   <= 1'b0;
            go_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            cnt_reg   <= cnt_next;
            lix_reg   <= lix_next;
            pad_reg   <= pad_next;
            go_reg    <= go_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `include "sha256_message_hasher_core_assert.svh"
    `SHA_ASSERT_IMPL(a_onehot_state, aclk, aresetn, 1'b1, $onehot(state_reg))
    `SHA_ASSERT_IMPL(a_ready_idle, aclk, aresetn, in_ready, !stat.busy)
    `SHA_ASSERT_NEXT(a_capture_clears, aclk, aresetn,
        cmd.capture, cnt_reg == 64'd0 && fill_reg == 6'd0)
    `SHA_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_valid && !out_ready, out_valid)
endmodule
`default_nettype wire

FILE: rtl/sha256_message_hasher_core.sv
// ----------------------------------------------------------------------------
// sha256_message_hasher_core
// SHA-256 hasher taking a byte stream and returning the 256-bit digest.
// ----------------------------------------------------------------------------
// Input channel s_: one transaction per byte; s_axis_tuser = 0 carries a message
// byte in s_axis_tdata, s_axis_tuser = 1 finishes the message (tdata ignored).
// Output channel m_: one transaction per finish, tdata holds the digest words.
// Intake: data bytes are taken back to back; the 64th byte of a block starts a
// compression that holds s_axis_tready low through the rounds, the fold into
// the chaining value and the return to byte intake.
// The compression time is set by the single round unit.
// Finish: pad byte and zeros are written one byte per cycle up to the length
// field, with a compression between when a block fills; the length bytes then
// start the last compression, and m_axis_tvalid rises once its fold is done.
// The digest waits in an output register, so the next message goes on while
// the receiver stalls; a second digest waits inside and holds off input until
// the register is taken. Handing a digest out reloads the initial hash.
// Reset (aresetn low, synchronous) restores the initial hash, clears counts
// and drops m_axis_tvalid.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_message_hasher_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,  // [7:0] data_byte
    input  wire logic         s_axis_tuser,  // [0] kind
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [63:0] digest_bits_255_192, [127:64] digest_bits_191_128,
    // [191:128] digest_bits_127_64, [255:192] digest_bits_63_0
    output logic [255:0]      m_axis_tdata
);
    sha_pkg::dp_cmd_t  cmd;
    sha_pkg::dp_stat_t stat;
    logic              byte_we;
    logic [5:0]        byte_addr;
    logic [7:0]        byte_data;
    logic [255:0]      digest;

    sha_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_kind(s_axis_tuser), .in_byte(s_axis_tdata),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .cmd(cmd), .stat(stat),
        .byte_we(byte_we), .byte_addr(byte_addr), .byte_data(byte_data)
    );

    sha_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
        .byte_we(byte_we), .byte_addr(byte_addr), .byte_data(byte_data),
        .stat(stat), .digest(digest)
    );

    assign m_axis_tdata = {digest[63:0], digest[127:64], digest[191:128], digest[255:192]};
endmodule
`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Byte-stream SHA-256 hasher check: directed and random messages are hashed
// by a local SHA-256 model and every digest transaction is compared per word.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
    localparam int MAX_CYCLES = 3000000;
    localparam int MAX_ERR_SHOWN = 10;

    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [255:0] m_axis_tdata;

    sha256_message_hasher_core dut (.*);

    always begin
        aclk = 1'b1; #4;
        aclk = 1'b0; #4;
    end

    // hash model state
    logic [31:0]  chain [8];
    logic [63:0]  bit_count;
    logic [7:0]   blk [64];
    int unsigned  fill;
    logic [255:0] digests_pending [$];

    int  n_bytes, n_finish, n_digests, n_err, cycles;
    int  rx_wait;
    bit  hold_off;
    bit  long_msg_seen;

    function automatic logic [31:0] ror(logic [31:0] v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    task automatic sha_compress();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int t = 0; t < 16; t++)
            w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
        for (int t = 16; t < 64; t++)
            w[t] = w[t-16] + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3))
                 + w[t-7] + (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10));
        {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                    chain[4], chain[5], chain[6], chain[7]};
        for (int t = 0; t < 64; t++) begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
               + sha_pkg::K[t] + w[t];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endtask

    task automatic sha_restart();
        for (int i = 0; i < 8; i++) chain[i] = sha_pkg::IV[i];
        bit_count = '0;
        fill = 0;
    endtask

    task automatic sha_absorb(logic kind, logic [7:0] data);
        int unsigned pos;
        if (kind == sha_pkg::KIND_DATA) begin
            bit_count += 64'd8;
            blk[fill] = data;
            fill = (fill + 1) % 64;
            if (fill == 0) sha_compress();
        end else begin
            pos = fill;
            blk[pos] = sha_pkg::PAD_BYTE;
            pos++;
            if (pos > sha_pkg::LEN_POS) begin
                for (int i = pos; i < 64; i++) blk[i] = 8'h00;
                sha_compress();
                pos = 0;
            end
            for (int i = pos; i < sha_pkg::LEN_POS; i++) blk[i] = 8'h00;
            for (int i = 0; i < 8; i++) blk[63-i] = bit_count[8*i +: 8];
            sha_compress();
            digests_pending.push_back({chain[6], chain[7], chain[4], chain[5],
                                       chain[2], chain[3], chain[0], chain[1]});
            sha_restart();
        end
    endtask

    // valid stays high after a transaction only when the next item follows at once
    task automatic send_item(logic kind, logic [7:0] data);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= data;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sha_absorb(kind, data);
        if (kind == sha_pkg::KIND_FINISH) n_finish++; else n_bytes++;
    endtask

    task automatic input_idle();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic send_message(int len);
        for (int i = 0; i < len; i++) send_item(sha_pkg::KIND_DATA, 8'($urandom));
        send_item(sha_pkg::KIND_FINISH, 8'($urandom));
    endtask

    // receiver: draws a random wait after each digest before taking the next, or holds off on request
    always @(posedge aclk) begin
        int w;
        if (aresetn !== 1'b1 || hold_off) begin
            m_axis_tready <= 1'b0;
            rx_wait       <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            w = $urandom_range(0, 5);
            rx_wait       <= w;
            m_axis_tready <= (w == 0);
        end else if (rx_wait > 0) begin
            rx_wait       <= rx_wait - 1;
            m_axis_tready <= (rx_wait == 1);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        logic [255:0] want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            n_digests++;
            if (digests_pending.size() == 0) begin
                n_err++;
                if (n_err <= MAX_ERR_SHOWN)
                    $display("unexpected digest %h", m_axis_tdata);
            end else begin
                want = digests_pending.pop_front();
                for (int i = 0; i < 4; i++)
                    if (m_axis_tdata[64*i +: 64] !== want[64*i +: 64]) begin
                        n_err++;
                        if (n_err <= MAX_ERR_SHOWN)
                            $display("digest word %0d: expected %h, got %h",
                                     i, want[64*i +: 64], m_axis_tdata[64*i +: 64]);
                    end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > MAX_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic test_edge_messages();
        send_item(sha_pkg::KIND_FINISH, 8'hff);      // empty message
        send_item(sha_pkg::KIND_DATA, 8'h00);
        send_item(sha_pkg::KIND_DATA, 8'hff);
        send_item(sha_pkg::KIND_FINISH, 8'h00);
    endtask

    task automatic test_pad_boundaries();
        // 55 bytes: one padding block; 56 and 63: two; 64: full block then pad
        send_message(55);
        send_message(56);
        send_message(63);
        send_message(64);
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                send_message(3);
                send_message(70);
                send_message(5);
                input_idle();
            end
            begin
                repeat (1500) @(posedge aclk);
                hold_off = 1'b0;
            end
        join
    endtask

    task automatic test_random_messages();
        int len;
        while (n_bytes + n_finish < 1950) begin
            case ($urandom_range(0, 9))
                0:       len = 0;
                1:       len = $urandom_range(120, 200);
                2:       len = 55 + $urandom_range(0, 9);
                default: len = $urandom_range(1, 40);
            endcase
            send_message(len);
        end
    endtask

    initial begin
        n_bytes = 0; n_finish = 0; n_digests = 0; n_err = 0; cycles = 0;
        hold_off = 1'b0;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        for (int i = 0; i < 64; i++) blk[i] = 8'h00;
        sha_restart();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_edge_messages();
        test_pad_boundaries();
        test_backpressure();
        test_random_messages();
        input_idle();

        while (digests_pending.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("hashed %0d message bytes in %0d messages, %0d digests checked",
                 n_bytes, n_finish, n_digests);
        $display("mismatches: %0d", n_err);
        if (n_err == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/sha_pkg.sv
rtl/sha_datapath.sv
rtl/sha_ctrl.sv
rtl/sha256_message_hasher_core.sv
tb/testbench.sv
